// ===== rtl/core/tcw_pkg.sv =====
// ---------------------------------------------------------------------------
// Text console writer package
// Geometry constants, field types, microcode encoding and the microcode ROM
// that sequences the console's character and attribute store.
// ---------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // Screen geometry.
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);

   // Fixed field widths of the channels.
   localparam int POS_W  = 11;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int BYTE_W = 8;
   localparam int CMD_W  = 2;

   localparam logic [7:0] BLANK_CHAR   = 8'd32;
   localparam logic [7:0] NEWLINE_CHAR = 8'd10;
   localparam logic [7:0] ATTR_RESET   = 8'h0F;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [ADDR_W:0]   addr_ext_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [BYTE_W-1:0] byte_type;

   // One stored cell: character in the upper byte, attribute in the lower.
   typedef logic [2*BYTE_W-1:0] cell_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // Microcode steps, in ROM order.
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_PUT,
      ST_NEWLINE,
      ST_CHECK,
      ST_COPY,
      ST_FILL,
      ST_OUT,
      ST_HOME,
      ST_READ
   } step_type;

   typedef enum logic [2:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_REQ,
      CND_LAST,
      CND_COPY_LAST,
      CND_NO_SCROLL,
      CND_OUT_FREE,
      CND_DISPATCH
   } cond_type;

   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_INC
   } ptr_op_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_BLANK_RESET,
      MEM_BLANK_ATTR,
      MEM_CHAR,
      MEM_COPY
   } mem_op_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_CELL,
      RD_ROW_BELOW,
      RD_ROW_BELOW_NEXT
   } rd_op_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_HOME,
      CUR_CHAR,
      CUR_NEWLINE
   } cur_op_type;

   typedef struct packed {
      cond_type   cond;
      step_type   target;
      logic       stay;
      logic       accept;
      ptr_op_type ptr_op;
      mem_op_type mem_op;
      rd_op_type  rd_op;
      cur_op_type cur_op;
      logic       load_rsp;
   } ctrl_word_type;

   // Datapath status seen by the sequencer.
   typedef struct packed {
      logic    last;
      logic    copy_last;
      logic    scroll;
      cmd_type cmd;
      logic    newline;
   } status_type;

   // Result assembled by the datapath for the output register.
   typedef struct packed {
      pos_type  cursor_pos;
      row_type  cursor_row;
      col_type  cursor_col;
      byte_type read_char;
      byte_type read_attr;
      logic     scrolled;
   } result_type;

   // Microcode ROM: one control word per step.
   function automatic ctrl_word_type ucode_word(input step_type step);
      ctrl_word_type cw;
      cw.cond     = CND_NEVER;
      cw.target   = ST_IDLE;
      cw.stay     = 1'b0;
      cw.accept   = 1'b0;
      cw.ptr_op   = PTR_HOLD;
      cw.mem_op   = MEM_NONE;
      cw.rd_op    = RD_NONE;
      cw.cur_op   = CUR_HOLD;
      cw.load_rsp = 1'b0;
      case (step)
         ST_INIT: begin
            cw.mem_op = MEM_BLANK_RESET;
            cw.ptr_op = PTR_INC;
            cw.cond   = CND_LAST;
            cw.target = ST_IDLE;
            cw.stay   = 1'b1;
         end
         ST_IDLE: begin
            cw.accept = 1'b1;
            cw.ptr_op = PTR_ZERO;
            cw.cond   = CND_REQ;
            cw.target = ST_DISPATCH;
            cw.stay   = 1'b1;
         end
         ST_DISPATCH: begin
            cw.cond = CND_DISPATCH;
         end
         ST_PUT: begin
            cw.mem_op = MEM_CHAR;
            cw.cur_op = CUR_CHAR;
            cw.cond   = CND_ALWAYS;
            cw.target = ST_CHECK;
         end
         ST_NEWLINE: begin
            cw.cur_op = CUR_NEWLINE;
         end
         ST_CHECK: begin
            cw.rd_op  = RD_ROW_BELOW;
            cw.cond   = CND_NO_SCROLL;
            cw.target = ST_OUT;
         end
         ST_COPY: begin
            cw.mem_op = MEM_COPY;
            cw.rd_op  = RD_ROW_BELOW_NEXT;
            cw.ptr_op = PTR_INC;
            cw.cond   = CND_COPY_LAST;
            cw.target = ST_FILL;
            cw.stay   = 1'b1;
         end
         ST_FILL: begin
            cw.mem_op = MEM_BLANK_ATTR;
            cw.ptr_op = PTR_INC;
            cw.cond   = CND_LAST;
            cw.target = ST_OUT;
            cw.stay   = 1'b1;
         end
         ST_OUT: begin
            cw.load_rsp = 1'b1;
            cw.cond     = CND_OUT_FREE;
            cw.target   = ST_IDLE;
            cw.stay     = 1'b1;
         end
         ST_HOME: begin
            cw.cur_op = CUR_HOME;
            cw.cond   = CND_ALWAYS;
            cw.target = ST_FILL;
         end
         ST_READ: begin
            cw.rd_op  = RD_CELL;
            cw.cond   = CND_ALWAYS;
            cw.target = ST_OUT;
         end
         default: begin
            cw.cond   = CND_ALWAYS;
            cw.target = ST_IDLE;
         end
      endcase
      return cw;
   endfunction

   // Jump table for the command dispatch step.
   function automatic step_type dispatch_step(input cmd_type cmd, input logic newline);
      step_type step;
      case (cmd)
         CMD_PUT:   step = newline ? ST_NEWLINE : ST_PUT;
         CMD_READ:  step = ST_READ;
         CMD_CLEAR: step = ST_HOME;
         default:   step = ST_OUT;
      endcase
      return step;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/text_console_writer.sv =====
// ---------------------------------------------------------------------------
// Text console writer
// An 80 x 25 text console with its own character and attribute store,
// driven by a small microcoded sequencer.
// ---------------------------------------------------------------------------
//
//   Port group   Direction   Transfer                 Contents
//   req_*        in          req_valid & !req_stall   cmd, char_code, cell_index
//   rsp_*        out         rsp_valid & !rsp_stall   cursor, read cell, scrolled
//   csr_*        in          csr_write_enable         text attribute byte
//
// A command takes its transfer in the idle step and then walks the microcode
// ROM one step per cycle, though a step that is flagged to stay repeats until
// its condition holds. A clear and a scroll each sweep the store one cell per
// cycle through its single write port.
// After reset the store is blanked by a clearing pass during which req_stall
// stays high; attribute writes are taken as ever.
// The result sits in an output register, so a stalled result only holds the
// sequencer in its output step; the next command is taken once it has gone.
//
`default_nettype none

module text_console_writer (
   input  wire                         clock,
   input  wire                         reset,

   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire  [tcw_pkg::CMD_W-1:0]   req_cmd,
   input  wire  [tcw_pkg::BYTE_W-1:0]  req_char_code,
   input  wire  [tcw_pkg::POS_W-1:0]   req_cell_index,

   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [tcw_pkg::POS_W-1:0]   rsp_cursor_pos,
   output logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]   rsp_cursor_col,
   output logic [tcw_pkg::BYTE_W-1:0]  rsp_read_char,
   output logic [tcw_pkg::BYTE_W-1:0]  rsp_read_attr,
   output logic                        rsp_scrolled,

   input  wire                         csr_write_enable,
   input  wire  [tcw_pkg::BYTE_W-1:0]  csr_write_data
);

   tcw_pkg::ctrl_word_type ctrl;
   tcw_pkg::status_type    status;
   tcw_pkg::result_type    result;

   logic                accept;
   logic                out_free;
   logic                load_rsp;
   logic                rsp_valid_ff, rsp_valid_in;
   tcw_pkg::result_type rsp_ff;

   // The only step that takes a command is the idle step, so stall is simply
   // the inverse of that step's accept bit.
   assign req_stall = !ctrl.accept;
   assign accept    = req_valid && ctrl.accept;

   // The output register may be refilled when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = ctrl.load_rsp && out_free;

   tcw_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .status    (status),
      .ctrl      (ctrl)
   );

   tcw_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .accept           (accept),
      .req_cmd          (req_cmd),
      .req_char_code    (req_char_code),
      .req_cell_index   (req_cell_index),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .result           (result)
   );

   // Result register and its valid flag.
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_ff.cursor_pos;
   assign rsp_cursor_row = rsp_ff.cursor_row;
   assign rsp_cursor_col = rsp_ff.cursor_col;
   assign rsp_read_char  = rsp_ff.read_char;
   assign rsp_read_attr  = rsp_ff.read_attr;
   assign rsp_scrolled   = rsp_ff.scrolled;

endmodule

`default_nettype wire

// ===== rtl/core/tcw_sequencer.sv =====
// ---------------------------------------------------------------------------
// Text console microcode sequencer
// Step counter with conditional jumps; looks up the control word per step.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_sequencer (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire                    out_free,
   input  tcw_pkg::status_type    status,
   output tcw_pkg::ctrl_word_type ctrl
);

   tcw_pkg::step_type pc_ff;
   tcw_pkg::step_type pc_in;
   logic              cond_true;

   // Output block: the ROM word for the current step.
   always_comb begin
      ctrl = tcw_pkg::ucode_word(pc_ff);
   end

   // Next-step block.
   always_comb begin
      case (ctrl.cond)
         tcw_pkg::CND_NEVER:     cond_true = 1'b0;
         tcw_pkg::CND_ALWAYS:    cond_true = 1'b1;
         tcw_pkg::CND_REQ:       cond_true = req_valid;
         tcw_pkg::CND_LAST:      cond_true = status.last;
         tcw_pkg::CND_COPY_LAST: cond_true = status.copy_last;
         tcw_pkg::CND_NO_SCROLL: cond_true = !status.scroll;
         tcw_pkg::CND_OUT_FREE:  cond_true = out_free;
         tcw_pkg::CND_DISPATCH:  cond_true = 1'b1;
         default:                cond_true = 1'b0;
      endcase

      if (cond_true) begin
         if (ctrl.cond == tcw_pkg::CND_DISPATCH) begin
            pc_in = tcw_pkg::dispatch_step(status.cmd, status.newline);
         end else begin
            pc_in = ctrl.target;
         end
      end else if (ctrl.stay) begin
         pc_in = pc_ff;
      end else begin
         pc_in = tcw_pkg::step_type'(pc_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= tcw_pkg::ST_INIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/tcw_datapath.sv =====
// ---------------------------------------------------------------------------
// Text console datapath
// Cell store, sweep pointer, cursor, attribute register and command latch.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_datapath (
   input  wire                          clock,
   input  wire                          reset,
   input  tcw_pkg::ctrl_word_type       ctrl,
   input  wire                          accept,
   input  wire  [tcw_pkg::CMD_W-1:0]    req_cmd,
   input  wire  [tcw_pkg::BYTE_W-1:0]   req_char_code,
   input  wire  [tcw_pkg::POS_W-1:0]    req_cell_index,
   input  wire                          csr_write_enable,
   input  wire  [tcw_pkg::BYTE_W-1:0]   csr_write_data,
   output tcw_pkg::status_type          status,
   output tcw_pkg::result_type          result
);

   localparam tcw_pkg::col_type  LAST_COL   = tcw_pkg::col_type'(tcw_pkg::COLUMNS - 1);
   localparam tcw_pkg::row_type  LAST_ROW   = tcw_pkg::row_type'(tcw_pkg::ROWS - 1);
   localparam tcw_pkg::addr_type LAST_CELL  = tcw_pkg::addr_type'(tcw_pkg::CELLS - 1);
   localparam tcw_pkg::addr_type COPY_LAST  =
      tcw_pkg::addr_type'(tcw_pkg::CELLS - tcw_pkg::COLUMNS - 1);
   localparam tcw_pkg::addr_type BOTTOM_POS =
      tcw_pkg::addr_type'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS);
   localparam tcw_pkg::addr_type ROW_STEP   = tcw_pkg::addr_type'(tcw_pkg::COLUMNS);
   localparam tcw_pkg::addr_ext_type CELLS_EXT = tcw_pkg::addr_ext_type'(tcw_pkg::CELLS);
   localparam tcw_pkg::addr_ext_type ROW_EXT   = tcw_pkg::addr_ext_type'(tcw_pkg::COLUMNS);

   tcw_pkg::cell_type mem [tcw_pkg::CELLS];

   tcw_pkg::cell_type     rdata_ff;
   tcw_pkg::addr_type     ptr_ff, ptr_in;
   tcw_pkg::addr_type     pos_ff, pos_in;
   tcw_pkg::row_type      row_ff, row_in;
   tcw_pkg::col_type      col_ff, col_in;
   logic                  scroll_ff, scroll_in;
   logic                  hit_ff, hit_in;
   tcw_pkg::byte_type     attr_ff;
   tcw_pkg::cmd_type      cmd_ff;
   tcw_pkg::byte_type     char_ff;
   tcw_pkg::addr_type     idx_ff;

   logic                  wr_en;
   tcw_pkg::addr_type     wr_addr;
   tcw_pkg::cell_type     wr_data;
   logic                  rd_en;
   tcw_pkg::addr_ext_type rd_addr_ext;

   // Store write and read ports.
   always_comb begin
      wr_en   = ctrl.mem_op != tcw_pkg::MEM_NONE;
      wr_addr = (ctrl.mem_op == tcw_pkg::MEM_CHAR) ? pos_ff : ptr_ff;
      case (ctrl.mem_op)
         tcw_pkg::MEM_BLANK_RESET: wr_data = {tcw_pkg::BLANK_CHAR, tcw_pkg::ATTR_RESET};
         tcw_pkg::MEM_BLANK_ATTR:  wr_data = {tcw_pkg::BLANK_CHAR, attr_ff};
         tcw_pkg::MEM_CHAR:        wr_data = {char_ff, attr_ff};
         tcw_pkg::MEM_COPY:        wr_data = rdata_ff;
         default:                  wr_data = {tcw_pkg::BLANK_CHAR, attr_ff};
      endcase

      case (ctrl.rd_op)
         tcw_pkg::RD_CELL: begin
            rd_addr_ext = {1'b0, idx_ff};
            rd_en       = hit_ff;
         end
         tcw_pkg::RD_ROW_BELOW: begin
            rd_addr_ext = {1'b0, ptr_ff} + ROW_EXT;
            rd_en       = rd_addr_ext < CELLS_EXT;
         end
         tcw_pkg::RD_ROW_BELOW_NEXT: begin
            rd_addr_ext = {1'b0, ptr_ff} + ROW_EXT + tcw_pkg::addr_ext_type'(1);
            rd_en       = rd_addr_ext < CELLS_EXT;
         end
         default: begin
            rd_addr_ext = {1'b0, ptr_ff};
            rd_en       = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr_ext[tcw_pkg::ADDR_W-1:0]];
      end
   end

   // Sweep pointer and cursor.
   always_comb begin
      case (ctrl.ptr_op)
         tcw_pkg::PTR_ZERO: ptr_in = '0;
         tcw_pkg::PTR_INC:  ptr_in = ptr_ff + tcw_pkg::addr_type'(1);
         default:           ptr_in = ptr_ff;
      endcase

      row_in    = row_ff;
      col_in    = col_ff;
      pos_in    = pos_ff;
      scroll_in = scroll_ff;
      case (ctrl.cur_op)
         tcw_pkg::CUR_HOME: begin
            row_in = '0;
            col_in = '0;
            pos_in = '0;
         end
         tcw_pkg::CUR_CHAR: begin
            pos_in = pos_ff + tcw_pkg::addr_type'(1);
            if (col_ff == LAST_COL) begin
               col_in = '0;
               if (row_ff == LAST_ROW) begin
                  pos_in    = BOTTOM_POS;
                  scroll_in = 1'b1;
               end else begin
                  row_in = row_ff + tcw_pkg::row_type'(1);
               end
            end else begin
               col_in = col_ff + tcw_pkg::col_type'(1);
            end
         end
         tcw_pkg::CUR_NEWLINE: begin
            col_in = '0;
            if (row_ff == LAST_ROW) begin
               pos_in    = BOTTOM_POS;
               scroll_in = 1'b1;
            end else begin
               row_in = row_ff + tcw_pkg::row_type'(1);
               pos_in = pos_ff - tcw_pkg::addr_type'(col_ff) + ROW_STEP;
            end
         end
         default: begin
            row_in = row_ff;
         end
      endcase

      // A new command starts without a scroll and decides whether it reads.
      hit_in = hit_ff;
      if (accept) begin
         scroll_in = 1'b0;
         hit_in    = (tcw_pkg::cmd_type'(req_cmd) == tcw_pkg::CMD_READ) &&
                     ({1'b0, req_cell_index} < CELLS_EXT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         pos_ff    <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         scroll_ff <= 1'b0;
         hit_ff    <= 1'b0;
         attr_ff   <= tcw_pkg::ATTR_RESET;
         cmd_ff    <= tcw_pkg::CMD_NONE;
      end else begin
         ptr_ff    <= ptr_in;
         pos_ff    <= pos_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         scroll_ff <= scroll_in;
         hit_ff    <= hit_in;
         if (csr_write_enable) begin
            attr_ff <= csr_write_data;
         end
         if (accept) begin
            cmd_ff <= tcw_pkg::cmd_type'(req_cmd);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_char_code;
         idx_ff  <= req_cell_index[tcw_pkg::ADDR_W-1:0];
      end
   end

   always_comb begin
      status.last      = ptr_ff == LAST_CELL;
      status.copy_last = ptr_ff == COPY_LAST;
      status.scroll    = scroll_ff;
      status.cmd       = cmd_ff;
      status.newline   = char_ff == tcw_pkg::NEWLINE_CHAR;

      result.cursor_pos = tcw_pkg::pos_type'(pos_ff);
      result.cursor_row = row_ff;
      result.cursor_col = col_ff;
      result.read_char  = hit_ff ? rdata_ff[2*tcw_pkg::BYTE_W-1:tcw_pkg::BYTE_W] : '0;
      result.read_attr  = hit_ff ? rdata_ff[tcw_pkg::BYTE_W-1:0] : '0;
      result.scrolled   = scroll_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/core/tcw_checker.sv =====
// ---------------------------------------------------------------------------
// Text console port checker
// Watches the result channel of the console and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         rsp_valid,
   input wire                         rsp_stall,
   input wire [tcw_pkg::POS_W-1:0]    rsp_cursor_pos,
   input wire [tcw_pkg::ROW_W-1:0]    rsp_cursor_row,
   input wire [tcw_pkg::COL_W-1:0]    rsp_cursor_col,
   input wire [tcw_pkg::BYTE_W-1:0]   rsp_read_char,
   input wire [tcw_pkg::BYTE_W-1:0]   rsp_read_attr,
   input wire                         rsp_scrolled
);

   // A stalled result stays offered, with its cursor position, read character and scroll flag unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cursor_pos)
         && $stable(rsp_read_char) && $stable(rsp_scrolled))
      else $error("result changed while stalled");

   // The linear cursor position agrees with row and column.
   a_pos_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_cursor_pos) ==
         int'(rsp_cursor_row) * tcw_pkg::COLUMNS + int'(rsp_cursor_col)))
      else $error("cursor position disagrees with row and column");

   // The cursor stays on the screen.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_cursor_row) < tcw_pkg::ROWS)
         && (int'(rsp_cursor_col) < tcw_pkg::COLUMNS))
      else $error("cursor off screen");

   // A scroll leaves the cursor at the start of the bottom row.
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> (int'(rsp_cursor_row) == tcw_pkg::ROWS - 1)
         && (rsp_cursor_col == '0))
      else $error("scroll with cursor not at bottom-left");

   // Only a read returns cell data, and a read never scrolls.
   a_read_no_scroll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_read_char != '0) || (rsp_read_attr != '0)) |-> !rsp_scrolled)
      else $error("cell data on a scrolling result");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_cursor_pos (rsp_cursor_pos),
   .rsp_cursor_row (rsp_cursor_row),
   .rsp_cursor_col (rsp_cursor_col),
   .rsp_read_char  (rsp_read_char),
   .rsp_read_attr  (rsp_read_attr),
   .rsp_scrolled   (rsp_scrolled)
);

`default_nettype wire
